>>> hw/rtl/twist_to_steer_speed_frame_core_defines.svh
// assertion helpers shared by the checkers
`ifndef TWIST_TO_STEER_SPEED_FRAME_CORE_DEFINES_SVH
`define TWIST_TO_STEER_SPEED_FRAME_CORE_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define TTSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define TTSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/ttsf_pkg.sv
package ttsf_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;

	// cordic datapath: x,y hold up to about 2^56 after gain, z up to about 100 deg * 2^16
	localparam int CW = 60;
	localparam int ZW = 26;

	localparam int IN_W    = 16;
	localparam int WB_W    = 16;
	localparam int MAX_W   = 7;
	localparam int START_W = 16;
	localparam int STEER_W = 8;
	localparam int SPEED_W = 13;
	localparam int CSUM_W  = 16;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

	localparam int          FRAC_BITS  = 16;
	localparam int          SCALE_BITS = 24;
	localparam logic [9:0]  MM_PER_M   = 10'd1000;
	// floor(n * 52429 / 2^19) equals n / 10 for every 16-bit n
	localparam logic [16:0] DIV10_MUL  = 17'd52429;
	localparam int          DIV10_SHR  = 19;

	localparam logic [1:0] REG_WHEEL_BASE = 2'd0;
	localparam logic [1:0] REG_MAX_STEER  = 2'd1;
	localparam logic [1:0] REG_START      = 2'd2;

	localparam logic [WB_W-1:0]    WHEEL_BASE_RST = 16'd600;
	localparam logic [MAX_W-1:0]   MAX_STEER_RST  = 7'd30;
	localparam logic [START_W-1:0] START_RST      = 16'hABCD;

	typedef struct packed {
		logic signed [CW-1:0]      x;
		logic signed [CW-1:0]      y;
		logic signed [ZW-1:0]      z;
		logic                      zero;
		logic signed [SPEED_W-1:0] speed;
	} cor_t;

	// atan(2^-i) in degrees, q16
	function automatic logic signed [ZW-1:0] atan_q16(input int idx);
		logic signed [ZW-1:0] a;
		case (idx)
			0:  a = 26'sd2949120;
			1:  a = 26'sd1740967;
			2:  a = 26'sd919879;
			3:  a = 26'sd466945;
			4:  a = 26'sd234379;
			5:  a = 26'sd117304;
			6:  a = 26'sd58666;
			7:  a = 26'sd29335;
			8:  a = 26'sd14668;
			9:  a = 26'sd7334;
			10: a = 26'sd3667;
			11: a = 26'sd1833;
			12: a = 26'sd917;
			13: a = 26'sd458;
			14: a = 26'sd229;
			15: a = 26'sd115;
			16: a = 26'sd57;
			17: a = 26'sd29;
			18: a = 26'sd14;
			19: a = 26'sd7;
			20: a = 26'sd4;
			21: a = 26'sd2;
			22: a = 26'sd1;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

endpackage

>>> hw/rtl/ttsf_cordic.sv
module ttsf_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	output logic          in_rdy,
	input  ttsf_pkg::cor_t in_dat,
	output logic          out_vld,
	input  logic          out_rdy,
	output ttsf_pkg::cor_t out_dat
);
	import ttsf_pkg::*;

	cor_t                     dat_s [CORDIC_STAGES];
	logic [CORDIC_STAGES-1:0] vld_s;
	logic [CORDIC_STAGES:0]   rdy;

	assign rdy[CORDIC_STAGES] = out_rdy;
	assign in_rdy  = rdy[0];
	assign out_vld = vld_s[CORDIC_STAGES-1];
	assign out_dat = dat_s[CORDIC_STAGES-1];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		cor_t                 prv;
		cor_t                 nxt;
		logic                 prv_vld;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		if (i == 0) begin : g_first
			assign prv     = in_dat;
			assign prv_vld = in_vld;
		end else begin : g_next
			assign prv     = dat_s[i-1];
			assign prv_vld = vld_s[i-1];
		end

		assign rdy[i] = ~vld_s[i] | rdy[i+1];
		assign dx = prv.y >>> i;
		assign dy = prv.x >>> i;

		// rotate toward y = 0, accumulate angle
		always_comb begin
			nxt = prv;
			if (!prv.y[CW-1]) begin
				nxt.x = prv.x + dx;
				nxt.y = prv.y - dy;
				nxt.z = prv.z + atan_q16(i);
			end else begin
				nxt.x = prv.x - dx;
				nxt.y = prv.y + dy;
				nxt.z = prv.z - atan_q16(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && prv_vld) begin
				dat_s[i] <= nxt;
			end
		end
	end

endmodule

>>> hw/rtl/twist_to_steer_speed_frame_core.sv
// velocity command to steering / speed frame
// s_axis carries one command per transaction: tdata[15:0] forward speed in mm/s,
// tdata[31:16] yaw rate in mrad/s, both two's complement.
// m_axis carries one frame per command: start word, steering angle in degrees
// (clamped to the configured limit, truncated toward zero), speed in cm/s and
// the xor checksum of the three as 16-bit patterns.
// cfg writes set wheel base, steering limit and start word; change them only
// while no command is in flight. cfg_ready is always high.
// the pipeline registers are stage 1 (multiply), stage 2 (scaling), one per
// cordic stage (16), stage 3 (clamp) and stage 4 (frame register). a new
// command is taken every cycle unless a stall on m_axis has filled the
// pipeline; the cordic stage chain does one rotation per stage.
// each stage has its own valid bit and ready, so bubbles close up and the
// input keeps flowing while a finished frame waits; a stall on m_axis backs up
// stage by stage without losing or repeating a command.
// reset empties the pipeline and restores the register defaults.
module twist_to_steer_speed_frame_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] linear_velocity_mms, [31:16] angular_velocity_mrads
	input  logic [ttsf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] start_word, [23:16] steer_deg, [36:24] speed_cms,
	// [52:37] checksum, [55:53] zero
	output logic [ttsf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [15:0]                         cfg_data
);
	import ttsf_pkg::*;

	logic [WB_W-1:0]    wheel_base_q;
	logic [MAX_W-1:0]   max_steer_q;
	logic [START_W-1:0] start_q;

	logic signed [IN_W-1:0] lin_v;
	logic signed [IN_W-1:0] ang_w;
	logic [IN_W:0]          neg_v;
	logic [IN_W-1:0]        abs_v;

	logic                   vld_s1, rdy1;
	logic                   vneg_s1, vzero_s1;
	logic [IN_W-1:0]        absv_s1;
	logic signed [32:0]     lw_s1;
	logic [31:0]            spd_s1;

	logic                   vld_s2, rdy2;
	cor_t                   cor_s2;
	logic [25:0]            xm;
	logic signed [33:0]     yn;
	logic [11:0]            spd_q;
	logic [SPEED_W-1:0]     spd_pos;

	logic                   cor_in_rdy, cor_out_vld;
	cor_t                   cor_out;

	logic                   vld_s3, rdy3;
	logic signed [ZW-1:0]   zc_s3;
	logic signed [SPEED_W-1:0] speed_s3;
	logic signed [ZW-1:0]   lim;
	logic signed [ZW-1:0]   zc;

	logic                   vld_s4, rdy4;
	logic [OUT_TDATA_W-1:0] tdata_s4;
	logic signed [ZW-1:0]   zmag;
	logic [STEER_W-1:0]     steer_mag;
	logic [STEER_W-1:0]     steer;
	logic [CSUM_W-1:0]      csum;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_base_q <= WHEEL_BASE_RST;
			max_steer_q  <= MAX_STEER_RST;
			start_q      <= START_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WHEEL_BASE: wheel_base_q <= cfg_data;
				REG_MAX_STEER:  max_steer_q  <= cfg_data[MAX_W-1:0];
				REG_START:      start_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: magnitude, wheel base times yaw rate, speed reciprocal product
	assign lin_v = $signed(s_axis_tdata[15:0]);
	assign ang_w = $signed(s_axis_tdata[31:16]);
	assign neg_v = 17'd0 - {lin_v[IN_W-1], lin_v};
	assign abs_v = lin_v[IN_W-1] ? neg_v[IN_W-1:0] : lin_v;
	assign rdy1  = ~vld_s1 | rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			vneg_s1  <= lin_v[IN_W-1];
			vzero_s1 <= (lin_v == '0);
			absv_s1  <= abs_v;
			lw_s1    <= $signed({1'b0, wheel_base_q}) * ang_w;
			spd_s1   <= 32'(abs_v) * 32'(DIV10_MUL);
		end
	end

	// stage 2: scaled cordic start vector, signed speed
	assign xm      = 26'(absv_s1) * 26'(MM_PER_M);
	assign yn      = vneg_s1 ? -34'(lw_s1) : 34'(lw_s1);
	assign spd_q   = spd_s1[DIV10_SHR+11:DIV10_SHR];
	assign spd_pos = {1'b0, spd_q};
	assign rdy2    = ~vld_s2 | cor_in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			cor_s2.x     <= $signed({{(CW-26-SCALE_BITS){1'b0}}, xm, {SCALE_BITS{1'b0}}});
			cor_s2.y     <= $signed({{(CW-34-SCALE_BITS){yn[33]}}, yn, {SCALE_BITS{1'b0}}});
			cor_s2.z     <= '0;
			cor_s2.zero  <= vzero_s1;
			cor_s2.speed <= vneg_s1 ? -spd_pos : spd_pos;
		end
	end

	ttsf_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.in_rdy  (cor_in_rdy),
		.in_dat  (cor_s2),
		.out_vld (cor_out_vld),
		.out_rdy (rdy3),
		.out_dat (cor_out)
	);

	// stage 3: clamp to the steering limit, zero speed forces zero angle
	assign lim  = $signed({{(ZW-MAX_W-FRAC_BITS){1'b0}}, max_steer_q, {FRAC_BITS{1'b0}}});
	assign rdy3 = ~vld_s3 | rdy4;

	always_comb begin
		if (cor_out.zero) begin
			zc = '0;
		end else if (cor_out.z > lim) begin
			zc = lim;
		end else if (cor_out.z < -lim) begin
			zc = -lim;
		end else begin
			zc = cor_out.z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy3) begin
			vld_s3 <= cor_out_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && cor_out_vld) begin
			zc_s3    <= zc;
			speed_s3 <= cor_out.speed;
		end
	end

	// stage 4: truncate toward zero, build the frame
	assign zmag      = zc_s3[ZW-1] ? -zc_s3 : zc_s3;
	assign steer_mag = zmag[FRAC_BITS+STEER_W-1:FRAC_BITS];
	assign steer     = zc_s3[ZW-1] ? -steer_mag : steer_mag;
	assign csum      = start_q ^ {{(CSUM_W-STEER_W){steer[STEER_W-1]}}, steer}
			^ {{(CSUM_W-SPEED_W){speed_s3[SPEED_W-1]}}, speed_s3};
	assign rdy4      = ~vld_s4 | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			tdata_s4 <= {3'b000, csum, speed_s3, steer, start_q};
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = tdata_s4;

endmodule

>>> hw/rtl/ttsf_checker.sv
`include "twist_to_steer_speed_frame_core_defines.svh"

module ttsf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	// a frame held back by the receiver stays put
	`TTSF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// checksum agrees with the fields of the same frame
	`TTSF_ASSERT_NOW(a_csum, clk, arst_n, m_axis_tvalid, m_axis_tdata[52:37] == (m_axis_tdata[15:0] ^ {{8{m_axis_tdata[23]}}, m_axis_tdata[23:16]} ^ {{3{m_axis_tdata[36]}}, m_axis_tdata[36:24]}))

	// steering never leaves plus or minus ninety degrees
	`TTSF_ASSERT_NOW(a_steer_rng, clk, arst_n, m_axis_tvalid, $signed(m_axis_tdata[23:16]) <= 8'sd90 && $signed(m_axis_tdata[23:16]) >= -8'sd90)

	// padding bits stay clear
	`TTSF_ASSERT_NOW(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[55:53] == 3'b000)

endmodule

bind twist_to_steer_speed_frame_core ttsf_checker u_ttsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/twist_to_steer_speed_frame_core_tb.sv
`timescale 1ns / 100ps

module twist_to_steer_speed_frame_core_tb;

	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          HOLD_LEN       = 150;
	localparam int          END_WAIT       = 40;
	localparam int          N_BLOCKS       = 6;
	localparam int          PER_BLOCK      = 267;
	localparam int          N_DIR          = 19;
	localparam logic [1:0]  REG_UNUSED     = 2'd3;

	// atan(2^-i) in degrees, q16
	localparam longint ATAN_DEG_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// same layout as m_axis_tdata, lowest field last
	typedef struct packed {
		logic [2:0]         pad;
		logic [15:0]        csum;
		logic signed [12:0] speed;
		logic signed [7:0]  steer;
		logic [15:0]        start;
	} frame_t;

	typedef struct {
		logic signed [15:0] v;
		logic signed [15:0] w;
		bit                 typed;
		logic signed [7:0]  steer;
		logic signed [12:0] speed;
		logic [15:0]        csum;
	} cmd_row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	// [15:0] linear_velocity_mms, [31:16] angular_velocity_mrads
	logic [31:0] s_axis_tdata   = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	// [15:0] start_word, [23:16] steer_deg, [36:24] speed_cms, [52:37] checksum
	logic [55:0] m_axis_tdata;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index      = '0;
	logic [15:0] cfg_data       = '0;

	logic [15:0] wheel_base_q = ttsf_pkg::WHEEL_BASE_RST;
	logic [6:0]  max_steer_q  = ttsf_pkg::MAX_STEER_RST;
	logic [15:0] start_q      = ttsf_pkg::START_RST;

	frame_t frames_q [$];
	int     fails         = 0;
	int     idle_mode     = 0;
	int     hold_requests = 0;
	int     hold_served   = 0;
	int     hold_left     = 0;
	int     stall_cycles  = 0;

	cmd_row_t dir_rows [N_DIR] = '{
		'{16'sd0,      16'sd0,      1'b1, 8'sd0,   13'sd0,     16'hABCD},
		'{16'sd0,      16'sh7FFF,   1'b1, 8'sd0,   13'sd0,     16'hABCD},
		'{16'sd0,      16'sh8000,   1'b1, 8'sd0,   13'sd0,     16'hABCD},
		'{16'sd5,      16'sd0,      1'b1, 8'sd0,   13'sd0,     16'hABCD},
		'{-16'sd1,     16'sd0,      1'b1, 8'sd0,   13'sd0,     16'hABCD},
		'{-16'sd10,    16'sd0,      1'b1, 8'sd0,   -13'sd1,    16'h5432},
		'{16'sh7FFF,   16'sh7FFF,   1'b1, 8'sd30,  13'sd3276,  16'hA71F},
		'{16'sh8000,   16'sh8000,   1'b1, 8'sd30,  -13'sd3276, 16'h58E7},
		'{16'sh7FFF,   16'sh8000,   1'b1, -8'sd30, 13'sd3276,  16'h58E3},
		'{16'sd1,      16'sh7FFF,   1'b0, 8'sd0,   13'sd0,     16'h0},
		'{16'sd1,      16'sh8000,   1'b0, 8'sd0,   13'sd0,     16'h0},
		'{-16'sd1,     16'sh7FFF,   1'b0, 8'sd0,   13'sd0,     16'h0},
		'{16'sh7FFF,   16'sd1,      1'b0, 8'sd0,   13'sd0,     16'h0},
		'{16'sh8000,   16'sd1,      1'b0, 8'sd0,   13'sd0,     16'h0},
		'{16'sh5555,   16'shAAAA,   1'b0, 8'sd0,   13'sd0,     16'h0},
		'{16'shAAAA,   16'sh5555,   1'b0, 8'sd0,   13'sd0,     16'h0},
		'{16'sd1000,   16'sd500,    1'b0, 8'sd0,   13'sd0,     16'h0},
		'{-16'sd3000,  -16'sd700,   1'b0, 8'sd0,   13'sd0,     16'h0},
		'{16'sd9,      -16'sd1,     1'b0, 8'sd0,   13'sd0,     16'h0}
	};

	twist_to_steer_speed_frame_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// steering frame for one velocity command under the current register copies
	function automatic frame_t predict_frame(input logic signed [15:0] v,
			input logic signed [15:0] w);
		longint x, y, z, dx, dy, lim;
		int     spd, ang, i;
		frame_t f;
		spd = int'(v) / 10;
		ang = 0;
		if (v != 0) begin
			x = (v < 0 ? -longint'(v) : longint'(v)) * 1000 * (longint'(1) << 24);
			y = longint'(wheel_base_q) * longint'(w) * (longint'(1) << 24);
			if (v < 0)
				y = -y;
			z = 0;
			for (i = 0; i < ttsf_pkg::CORDIC_STAGES && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx;
					y -= dy;
					z += ATAN_DEG_Q16[i];
				end else begin
					x -= dx;
					y += dy;
					z -= ATAN_DEG_Q16[i];
				end
			end
			lim = longint'(max_steer_q) * 65536;
			if (z > lim)
				z = lim;
			if (z < -lim)
				z = -lim;
			ang = (z >= 0) ? int'(z >>> 16) : -int'((-z) >>> 16);
		end
		f.pad   = '0;
		f.start = start_q;
		f.steer = 8'(ang);
		f.speed = 13'(spd);
		f.csum  = start_q ^ 16'(ang) ^ 16'(spd);
		return f;
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			2: return 16'($urandom_range(40)) - 16'd20;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int sender_idle_pct();
		case (idle_mode)
			0: return 19;
			1: return 77;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (idle_mode)
			0: return 77;
			1: return 19;
			default: return 0;
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			ttsf_pkg::REG_WHEEL_BASE: wheel_base_q = data;
			ttsf_pkg::REG_MAX_STEER:  max_steer_q  = data[6:0];
			ttsf_pkg::REG_START:      start_q      = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_vehicle(input logic [15:0] wb, input logic [15:0] lim,
			input logic [15:0] marker);
		cfg_write(ttsf_pkg::REG_WHEEL_BASE, wb);
		cfg_write(ttsf_pkg::REG_MAX_STEER, lim);
		cfg_write(ttsf_pkg::REG_START, marker);
	endtask

	// called and returns at a falling edge; valid stays high for the next command
	task automatic send_cmd(input logic signed [15:0] v, input logic signed [15:0] w,
			input bit typed, input frame_t typed_frame);
		while ($urandom_range(99) < sender_idle_pct()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {w, v};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		frames_q.push_back(typed ? typed_frame : predict_frame(v, w));
		@(negedge clk);
	endtask

	task automatic stop_and_drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (frames_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		frame_t tf;
		static logic [15:0] wb_set  [N_BLOCKS] = '{16'd600, 16'd65535, 16'd1, 16'd0,
			16'd1234, 16'd250};
		static logic [15:0] lim_set [N_BLOCKS] = '{16'd30, 16'd90, 16'd0, 16'hFF85,
			16'hFFFF, 16'd45};
		static logic [15:0] mk_set  [N_BLOCKS] = '{16'hABCD, 16'hFFFF, 16'h0000,
			16'h5A5A, 16'h8001, 16'h7FFE};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// a write to the unused index must leave the reset values alone
		cfg_write(REG_UNUSED, 16'hFFFF);
		for (int r = 0; r < N_DIR; r++) begin
			tf = {3'b000, dir_rows[r].csum, dir_rows[r].speed, dir_rows[r].steer,
				start_q};
			send_cmd(dir_rows[r].v, dir_rows[r].w, dir_rows[r].typed, tf);
		end
		stop_and_drain();

		for (int b = 0; b < N_BLOCKS; b++) begin
			idle_mode = b / 2;
			set_vehicle(wb_set[b], lim_set[b], mk_set[b]);
			for (int k = 0; k < PER_BLOCK; k++) begin
				if (b == 4 && k == 40)
					hold_requests++;
				if (b == 5 && k == 100)
					stop_and_drain();
				send_cmd(pick_value(), pick_value(), 1'b0, '0);
			end
			stop_and_drain();
		end

		repeat (END_WAIT) @(negedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// receiver backpressure, plus a single long hold-off to fill the pipeline
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		frame_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = frame_t'(m_axis_tdata);
			if (frames_q.size() == 0) begin
				$error("frame with no command outstanding: %h", m_axis_tdata);
				fails++;
			end else begin
				want = frames_q.pop_front();
				if (got.start !== want.start) begin
					$error("start_word: expected %h, got %h", want.start, got.start);
					fails++;
				end
				if (got.steer !== want.steer) begin
					$error("steer_deg: expected %0d, got %0d", want.steer, got.steer);
					fails++;
				end
				if (got.speed !== want.speed) begin
					$error("speed_cms: expected %0d, got %0d", want.speed, got.speed);
					fails++;
				end
				if (got.csum !== want.csum) begin
					$error("checksum: expected %h, got %h", want.csum, got.csum);
					fails++;
				end
				if (got.pad !== want.pad) begin
					$error("tdata padding: expected %h, got %h", want.pad, got.pad);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

endmodule
